// ----- rtl/shth_pkg.sv -----
// Package for the swiss hash table block: request and status codes,
// slot layout constants, controller state type and probe result struct.
// No dependencies.
`default_nettype none
package shth_pkg;

	localparam int HASH_W  = 64;
	localparam int TAG_W   = 32;
	localparam int VALUE_W = 32;
	localparam int FP_W    = 7;
	localparam int TOTAL_W = 11;
	localparam int CFG_W   = 3;
	localparam int LAP_W   = 8;
	localparam int HASH_LSB  = 0;
	localparam int TAG_LSB   = HASH_LSB + HASH_W;
	localparam int VALUE_LSB = TAG_LSB + TAG_W;
	localparam int ERASE_LSB = VALUE_LSB + VALUE_W;
	localparam int SLOT_W    = ERASE_LSB + 1;
	localparam int GRP_SHIFT = 7;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_UPSERT = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	localparam logic [1:0] ST_HIT      = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic [2:0] CFG_RESET = 3'd7;

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_PROBE
	} fsm_t;

	typedef struct packed {
		logic found;
		logic empty;
	} probe_res_t;

endpackage
`default_nettype wire

// ----- rtl/shth_req_if.sv -----
// Request, response and configuration channel interfaces.
// Depends on shth_pkg for field widths.
`default_nettype none
interface shth_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   req_type;
	logic [shth_pkg::HASH_W-1:0]  key_digest;
	logic [shth_pkg::TAG_W-1:0]   key_tag;
	logic [shth_pkg::VALUE_W-1:0] entry_value;
	logic                         erase_flag;
	modport source (output valid, req_type, key_digest, key_tag, entry_value, erase_flag,
		input ready);
	modport sink (input valid, req_type, key_digest, key_tag, entry_value, erase_flag,
		output ready);
endinterface

interface shth_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic                          was_new;
	logic [shth_pkg::VALUE_W-1:0]  found_value;
	logic                          found_erase;
	logic [shth_pkg::TOTAL_W-1:0]  entry_total;
	modport source (output valid, status, was_new, found_value, found_erase, entry_total,
		input ready);
	modport sink (input valid, status, was_new, found_value, found_erase, entry_total,
		output ready);
endinterface

interface shth_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [shth_pkg::CFG_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/shth_store.sv -----
// Group-row storage: control fingerprint memory and slot data memory,
// one row per probe group, registered read data. Depends on shth_pkg.
`default_nettype none
module shth_store #(
	parameter int ROWS    = 128,
	parameter int GS      = 8,
	parameter int RW      = 7
) (
	input  wire logic                           clk,
	input  wire logic                           rd_en,
	input  wire logic [RW-1:0]                  rd_addr,
	input  wire logic                           wr_en,
	input  wire logic                           data_we,
	input  wire logic [RW-1:0]                  wr_addr,
	input  wire logic [GS*shth_pkg::FP_W-1:0]   ctrl_wdata,
	input  wire logic [GS*shth_pkg::SLOT_W-1:0] data_wdata,
	output logic      [GS*shth_pkg::FP_W-1:0]   ctrl_rdata,
	output logic      [GS*shth_pkg::SLOT_W-1:0] data_rdata
);

	logic [GS*shth_pkg::FP_W-1:0]   ctrl_mem [ROWS];
	logic [GS*shth_pkg::SLOT_W-1:0] data_mem [ROWS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ctrl_mem[wr_addr] <= ctrl_wdata;
		end
		if (rd_en) begin
			ctrl_rdata <= ctrl_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && data_we) begin
			data_mem[wr_addr] <= data_wdata;
		end
		if (rd_en) begin
			data_rdata <= data_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/shth_probe.sv -----
// Group match logic: compares every lane of one row and picks the first
// empty or matching slot. Depends on shth_pkg.
`default_nettype none
module shth_probe #(
	parameter int GS = 8,
	parameter int SW = 3
) (
	input  wire logic [GS*shth_pkg::FP_W-1:0]   ctrl_row,
	input  wire logic [GS*shth_pkg::SLOT_W-1:0] data_row,
	input  wire logic [shth_pkg::FP_W-1:0]      want_fp,
	input  wire logic [shth_pkg::HASH_W-1:0]    hash,
	input  wire logic [shth_pkg::TAG_W-1:0]     tag,
	output shth_pkg::probe_res_t                res,
	output logic      [SW-1:0]                  lane
);

	always_comb begin
		logic [shth_pkg::FP_W-1:0]   fp;
		logic [shth_pkg::SLOT_W-1:0] slot;
		logic                        is_match;
		res  = '0;
		lane = '0;
		for (int i = GS - 1; i >= 0; i--) begin
			fp   = ctrl_row[i*shth_pkg::FP_W +: shth_pkg::FP_W];
			slot = data_row[i*shth_pkg::SLOT_W +: shth_pkg::SLOT_W];
			is_match = (fp == want_fp)
				&& (slot[shth_pkg::HASH_LSB +: shth_pkg::HASH_W] == hash)
				&& (slot[shth_pkg::TAG_LSB +: shth_pkg::TAG_W] == tag);
			if (fp == '0) begin
				res.empty = 1'b1;
				res.found = 1'b0;
				lane      = SW'(i);
			end else if (is_match) begin
				res.empty = 1'b0;
				res.found = 1'b1;
				lane      = SW'(i);
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/swiss_hash_table_upsert_lookup_top.sv -----
// Swiss hash table top: request controller, probe sequencing, clearing sweep.
// Depends on shth_pkg, shth_req_if interfaces, shth_store, shth_probe.
// Lookup/upsert: one row read of the group memory per probed group, the first
//   at accept; result registered once the response register is free.
// Clear: sweeps all SLOT_COUNT/GROUP_SIZE control rows, one control row per cycle, then result.
// Reset: async, active low; the same sweep runs after reset, no request taken.
`default_nettype none
module swiss_hash_table_upsert_lookup_top #(
	parameter int SLOT_COUNT = 1024,
	parameter int GROUP_SIZE = 8
) (
	input wire logic   clk,
	input wire logic   arst_n,
	shth_req_if.sink   req,
	shth_rsp_if.source rsp,
	shth_cfg_if.sink   cfg
);

	localparam int ROWS     = SLOT_COUNT / GROUP_SIZE;
	localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SW       = $clog2(GROUP_SIZE);
	localparam int ROW_LOG2 = $clog2(ROWS + 1) - 1;
	localparam int CW       = $clog2(SLOT_COUNT + 1);
	localparam int FPW      = shth_pkg::FP_W;
	localparam int SLW      = shth_pkg::SLOT_W;

	shth_pkg::fsm_t state_q, state_d;

	logic [1:0]                   op_q;
	logic [shth_pkg::HASH_W-1:0]  hash_q;
	logic [shth_pkg::TAG_W-1:0]   tag_q;
	logic [shth_pkg::VALUE_W-1:0] val_q;
	logic                         er_q;
	logic [RW-1:0]                grp_q;
	logic [shth_pkg::LAP_W-1:0]   lap_q;
	logic                         clr_req_q;
	logic [RW-1:0]                clr_row_q;
	logic [CW-1:0]                count_q, count_d;
	logic [shth_pkg::CFG_W-1:0]   cfg_q;
	logic                         rsp_valid_q;
	logic [1:0]                   status_q;
	logic                         was_new_q;
	logic [shth_pkg::VALUE_W-1:0] fval_q;
	logic                         ferase_q;
	logic [CW-1:0]                total_q;

	logic [shth_pkg::CFG_W-1:0] eff_log2;
	logic [RW-1:0]              grp_mask, start_grp, next_grp;
	logic                       lap_last, out_free, accept, clr_last;
	logic [FPW-1:0]             want_fp;

	logic                   rd_en, wr_en, data_we;
	logic [RW-1:0]          rd_addr, wr_addr;
	logic [GROUP_SIZE*FPW-1:0] ctrl_rd, ctrl_wr;
	logic [GROUP_SIZE*SLW-1:0] data_rd, data_wr;

	shth_pkg::probe_res_t pr;
	logic [SW-1:0]        lane;
	logic [SLW-1:0]       lane_slot;

	logic       done, load_out, bump;
	logic [1:0] status_d;
	logic       was_new_d;
	logic [shth_pkg::VALUE_W-1:0] fval_d;
	logic       ferase_d;
	logic [31:0] total_ext;

	assign eff_log2  = (int'(cfg_q) > ROW_LOG2) ? shth_pkg::CFG_W'(ROW_LOG2) : cfg_q;
	assign grp_mask  = RW'((32'd1 << eff_log2) - 32'd1);
	assign lap_last  = lap_q == shth_pkg::LAP_W'((32'd1 << eff_log2) - 32'd1);
	assign start_grp = req.key_digest[shth_pkg::GRP_SHIFT +: RW] & grp_mask;
	assign next_grp  = (grp_q + RW'(1)) & grp_mask;
	assign want_fp   = (hash_q[FPW-1:0] == '0) ? FPW'(1) : hash_q[FPW-1:0];
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = state_q == shth_pkg::FSM_IDLE;
	assign accept    = req.valid && req.ready;
	assign clr_last  = clr_row_q == RW'(ROWS - 1);
	assign cfg.ready = 1'b1;
	assign lane_slot = data_rd[lane*SLW +: SLW];

	shth_store #(.ROWS(ROWS), .GS(GROUP_SIZE), .RW(RW)) u_store (
		.clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .wr_en(wr_en), .data_we(data_we),
		.wr_addr(wr_addr), .ctrl_wdata(ctrl_wr), .data_wdata(data_wr),
		.ctrl_rdata(ctrl_rd), .data_rdata(data_rd)
	);

	shth_probe #(.GS(GROUP_SIZE), .SW(SW)) u_probe (
		.ctrl_row(ctrl_rd), .data_row(data_rd), .want_fp(want_fp), .hash(hash_q),
		.tag(tag_q), .res(pr), .lane(lane)
	);

	// probe decision
	always_comb begin
		done      = 1'b1;
		bump      = 1'b0;
		status_d  = shth_pkg::ST_NOTFOUND;
		was_new_d = 1'b0;
		fval_d    = '0;
		ferase_d  = 1'b0;
		case (op_q)
			shth_pkg::REQ_LOOKUP: begin
				done = pr.found || pr.empty || lap_last;
				if (pr.found) begin
					status_d = shth_pkg::ST_HIT;
					fval_d   = lane_slot[shth_pkg::VALUE_LSB +: shth_pkg::VALUE_W];
					ferase_d = lane_slot[shth_pkg::ERASE_LSB];
				end
			end
			shth_pkg::REQ_UPSERT: begin
				done = pr.found || pr.empty || lap_last;
				if (pr.found || pr.empty) begin
					status_d  = shth_pkg::ST_HIT;
					was_new_d = pr.empty;
					bump      = 1'b1;
				end else begin
					status_d = shth_pkg::ST_FULL;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			shth_pkg::FSM_CLEAR: begin
				if (clr_last && (!clr_req_q || out_free)) begin
					state_d = shth_pkg::FSM_IDLE;
				end
			end
			shth_pkg::FSM_IDLE: begin
				if (accept) begin
					state_d = (req.req_type == shth_pkg::REQ_CLEAR) ? shth_pkg::FSM_CLEAR
						: shth_pkg::FSM_PROBE;
				end
			end
			shth_pkg::FSM_PROBE: begin
				if (done && out_free) begin
					state_d = shth_pkg::FSM_IDLE;
				end
			end
			default: state_d = shth_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = start_grp;
		wr_en    = 1'b0;
		data_we  = 1'b0;
		wr_addr  = grp_q;
		ctrl_wr  = ctrl_rd;
		data_wr  = data_rd;
		load_out = 1'b0;
		count_d  = count_q;
		ctrl_wr[lane*FPW +: FPW] = want_fp;
		data_wr[lane*SLW +: SLW] = {er_q, val_q, tag_q, hash_q};
		case (state_q)
			shth_pkg::FSM_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_row_q;
				ctrl_wr = '0;
				count_d = '0;
				load_out = clr_last && clr_req_q && out_free;
			end
			shth_pkg::FSM_IDLE: begin
				rd_en = accept;
				if (accept && req.req_type == shth_pkg::REQ_CLEAR) begin
					count_d = '0;
				end
			end
			shth_pkg::FSM_PROBE: begin
				if (!done) begin
					rd_en   = 1'b1;
					rd_addr = next_grp;
				end else if (out_free) begin
					load_out = 1'b1;
					wr_en    = bump;
					data_we  = bump;
					if (was_new_d) begin
						count_d = count_q + CW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= shth_pkg::FSM_CLEAR;
			clr_req_q   <= 1'b0;
			clr_row_q   <= '0;
			count_q     <= '0;
			cfg_q       <= shth_pkg::CFG_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg.valid) begin
				cfg_q <= cfg.data;
			end
			if (accept && req.req_type == shth_pkg::REQ_CLEAR) begin
				clr_row_q <= '0;
			end else if (state_q == shth_pkg::FSM_CLEAR && !clr_last) begin
				clr_row_q <= clr_row_q + RW'(1);
			end
			if (accept && req.req_type == shth_pkg::REQ_CLEAR) begin
				clr_req_q <= 1'b1;
			end else if (state_q == shth_pkg::FSM_CLEAR && state_d == shth_pkg::FSM_IDLE) begin
				clr_req_q <= 1'b0;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.req_type;
			hash_q <= req.key_digest;
			tag_q  <= req.key_tag;
			val_q  <= req.entry_value;
			er_q   <= req.erase_flag;
			grp_q  <= start_grp;
			lap_q  <= '0;
		end else if (state_q == shth_pkg::FSM_PROBE && !done) begin
			grp_q <= next_grp;
			lap_q <= lap_q + shth_pkg::LAP_W'(1);
		end
		if (load_out) begin
			status_q  <= (state_q == shth_pkg::FSM_CLEAR) ? shth_pkg::ST_HIT : status_d;
			was_new_q <= (state_q == shth_pkg::FSM_CLEAR) ? 1'b0 : was_new_d;
			fval_q    <= (state_q == shth_pkg::FSM_CLEAR) ? '0 : fval_d;
			ferase_q  <= (state_q == shth_pkg::FSM_CLEAR) ? 1'b0 : ferase_d;
			total_q   <= count_d;
		end
	end

	assign total_ext       = 32'(total_q);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.was_new     = was_new_q;
	assign rsp.found_value = fval_q;
	assign rsp.found_erase = ferase_q;
	assign rsp.entry_total = total_ext[shth_pkg::TOTAL_W-1:0];

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == shth_pkg::FSM_CLEAR) |-> !req.ready)
		else $error("request accepted during clear sweep");
	a_clear_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.req_type == shth_pkg::REQ_CLEAR) |=>
		(state_q == shth_pkg::FSM_CLEAR && count_q == '0))
		else $error("clear request did not start sweep");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= SLOT_COUNT)
		else $error("occupied count beyond capacity");
	a_lap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == shth_pkg::FSM_PROBE) |-> !(lap_last && !done))
		else $error("probe ran past one lap");

endmodule
`default_nettype wire

// ----- tb/sv/tb_swiss_hash_table_upsert_lookup_top.sv -----
// Testbench for the swiss hash table: directed table of requests, a single-group fill phase,
// then random keyed traffic and config phases, all checked against an in-bench table model.
// Depends on shth_pkg, the shth interfaces and swiss_hash_table_upsert_lookup_top.
`timescale 1ns / 100ps
module tb_swiss_hash_table_upsert_lookup_top;

	localparam int SLOTS = 1024;
	localparam int GSIZE = 8;
	localparam logic [1:0] REQ_NOP = 2'd3;

	typedef struct {
		logic [1:0]  op;
		logic [63:0] hash;
		logic [31:0] tag;
		logic [31:0] value;
		logic        erase;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        was_new;
		logic [31:0] value;
		logic        erase;
		logic [10:0] total;
	} answer_t;

	typedef struct {
		request_t req;
		bit       typed;
		answer_t  ans;
	} vector_t;

	logic clk;
	logic arst_n;
	shth_req_if req_ch();
	shth_rsp_if rsp_ch();
	shth_cfg_if cfg_ch();

	swiss_hash_table_upsert_lookup_top uut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source), .cfg(cfg_ch.sink)
	);

	logic [6:0]  ctrl_mem [SLOTS];
	logic [63:0] hash_mem [SLOTS];
	logic [31:0] tag_mem [SLOTS];
	logic [31:0] value_mem [SLOTS];
	logic        erase_mem [SLOTS];
	int unsigned used_slots;
	logic [2:0]  groups_log2;

	answer_t pending_answers[$];
	logic [63:0] key_hashes[$];
	logic [31:0] key_tags[$];
	int errors;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [6:0] fingerprint(logic [63:0] h);
		return (h[6:0] == 0) ? 7'd1 : h[6:0];
	endfunction

	// 0 match, 1 empty slot, 2 lap done
	function automatic int probe_table(logic [63:0] h, logic [31:0] t, output int slot);
		int groups, grp, base;
		groups = 1 << groups_log2;
		while (groups > 1 && groups * GSIZE > SLOTS) groups >>= 1;
		grp = int'((h >> shth_pkg::GRP_SHIFT) & 64'(groups - 1));
		slot = 0;
		for (int n = 0; n < groups; n++) begin
			base = grp * GSIZE;
			for (int o = 0; o < GSIZE; o++) begin
				if (base + o >= SLOTS) return 2;
				if (ctrl_mem[base + o] == 0) begin
					slot = base + o;
					return 1;
				end
				if (ctrl_mem[base + o] == fingerprint(h) && hash_mem[base + o] == h
						&& tag_mem[base + o] == t) begin
					slot = base + o;
					return 0;
				end
			end
			grp++;
			if (grp == groups) grp = 0;
		end
		return 2;
	endfunction

	function automatic answer_t apply_request(request_t r);
		answer_t a;
		int s, res;
		a = '{shth_pkg::ST_NOTFOUND, 1'b0, 32'd0, 1'b0, 11'd0};
		if (r.op == shth_pkg::REQ_LOOKUP) begin
			res = probe_table(r.hash, r.tag, s);
			if (res == 0) begin
				a.status = shth_pkg::ST_HIT;
				a.value = value_mem[s];
				a.erase = erase_mem[s];
			end
		end else if (r.op == shth_pkg::REQ_UPSERT) begin
			res = probe_table(r.hash, r.tag, s);
			if (res == 2) a.status = shth_pkg::ST_FULL;
			else begin
				a.status = shth_pkg::ST_HIT;
				if (res == 1) begin
					a.was_new = 1;
					used_slots++;
				end
				ctrl_mem[s] = fingerprint(r.hash);
				hash_mem[s] = r.hash;
				tag_mem[s] = r.tag;
				value_mem[s] = r.value;
				erase_mem[s] = r.erase;
			end
		end else if (r.op == shth_pkg::REQ_CLEAR) begin
			foreach (ctrl_mem[i]) ctrl_mem[i] = 0;
			used_slots = 0;
			a.status = shth_pkg::ST_HIT;
		end
		a.total = 11'(used_slots);
		return a;
	endfunction

	task automatic send_request(request_t r, bit typed, answer_t typed_ans);
		answer_t a;
		int idle;
		idle = $urandom_range(0, 5);
		if (idle != 0) begin
			req_ch.valid <= 0;
			repeat (idle) @(posedge clk);
		end
		a = apply_request(r);
		if (typed && a != typed_ans) begin
			$error("directed row: predictor disagrees with typed answer");
			errors++;
		end
		pending_answers.insert(pending_answers.size(), typed ? typed_ans : a);
		req_ch.valid <= 1;
		req_ch.req_type <= r.op;
		req_ch.key_digest <= r.hash;
		req_ch.key_tag <= r.tag;
		req_ch.entry_value <= r.value;
		req_ch.erase_flag <= r.erase;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		req_ch.valid <= 0;
		while (pending_answers.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (300) @(posedge clk);
	endtask

	task automatic write_groups(logic [2:0] v);
		cfg_ch.valid <= 1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 0;
		groups_log2 = v;
	endtask

	function automatic request_t random_request(int mode);
		request_t r;
		int k;
		r.value = $urandom;
		r.erase = $urandom_range(0, 1);
		r.tag = $urandom;
		r.hash = {$urandom, $urandom};
		k = $urandom_range(0, 99);
		r.op = (k < 50) ? shth_pkg::REQ_UPSERT : (k < 92) ? shth_pkg::REQ_LOOKUP :
			(k < 94) ? shth_pkg::REQ_CLEAR : (k < 96) ? REQ_NOP : shth_pkg::REQ_LOOKUP;
		if (key_hashes.size() != 0 && $urandom_range(0, 99) < 55) begin
			k = $urandom_range(0, key_hashes.size() - 1);
			r.hash = key_hashes[k];
			r.tag = ($urandom_range(0, 9) == 0) ? ~key_tags[k] : key_tags[k];
		end else begin
			// few groups and colliding fingerprints reach collisions and laps
			if (mode == 1) r.hash[6:0] = $urandom_range(0, 3);
			key_hashes.insert(key_hashes.size(), r.hash);
			key_tags.insert(key_tags.size(), r.tag);
			if (key_hashes.size() > 200) begin
				void'(key_hashes.pop_front());
				void'(key_tags.pop_front());
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		answer_t e;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_answers.size() == 0) begin
				$error("response transaction with no request outstanding");
				errors++;
			end else begin
				e = pending_answers.pop_front();
				if (rsp_ch.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, rsp_ch.status); errors++;
				end
				if (rsp_ch.was_new !== e.was_new) begin
					$error("was_new exp %0d got %0d", e.was_new, rsp_ch.was_new); errors++;
				end
				if (rsp_ch.found_value !== e.value) begin
					$error("found_value exp %h got %h", e.value, rsp_ch.found_value); errors++;
				end
				if (rsp_ch.found_erase !== e.erase) begin
					$error("found_erase exp %0d got %0d", e.erase, rsp_ch.found_erase); errors++;
				end
				if (rsp_ch.entry_total !== e.total) begin
					$error("entry_total exp %0d got %0d", e.total, rsp_ch.entry_total); errors++;
				end
			end
		end
	end

	// receiver stalls: per transaction ready is dropped for a random wait, or not at all
	initial begin
		int stall;
		rsp_ch.ready = 0;
		forever begin
			stall = $urandom_range(0, 5);
			if ($urandom_range(0, 3) == 0) stall = 0;
			@(posedge clk);
			if (stall != 0) begin
				rsp_ch.ready <= 0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	vector_t directed[$];

	initial begin
		request_t r;
		answer_t z;
		logic [2:0] phase_cfg[6];
		phase_cfg = '{3'd0, 3'd7, 3'd1, 3'd3, 3'd0, 3'd6};
		errors = 0;
		foreach (ctrl_mem[i]) ctrl_mem[i] = 0;
		used_slots = 0;
		groups_log2 = shth_pkg::CFG_RESET;
		arst_n = 0;
		req_ch.valid = 0; req_ch.req_type = shth_pkg::REQ_LOOKUP; req_ch.key_digest = 0;
		req_ch.key_tag = 0; req_ch.entry_value = 0; req_ch.erase_flag = 0;
		cfg_ch.valid = 0; cfg_ch.data = 0;
		z = '{shth_pkg::ST_NOTFOUND, 1'b0, 32'd0, 1'b0, 11'd0};

		directed = '{
			'{'{shth_pkg::REQ_LOOKUP, 64'h0, 32'h0, 32'h0, 1'b0}, 1, z},
			'{'{shth_pkg::REQ_UPSERT, 64'h0, 32'h0, 32'hFFFFFFFF, 1'b1}, 1,
				'{shth_pkg::ST_HIT, 1'b1, 32'd0, 1'b0, 11'd1}},
			'{'{shth_pkg::REQ_LOOKUP, 64'h0, 32'h0, 32'h0, 1'b0}, 1,
				'{shth_pkg::ST_HIT, 1'b0, 32'hFFFFFFFF, 1'b1, 11'd1}},
			'{'{shth_pkg::REQ_UPSERT, 64'hFFFFFFFFFFFFFFFF, 32'hFFFFFFFF, 32'h1234, 1'b0}, 1,
				'{shth_pkg::ST_HIT, 1'b1, 32'd0, 1'b0, 11'd2}},
			'{'{shth_pkg::REQ_UPSERT, 64'hFFFFFFFFFFFFFFFF, 32'hFFFFFFFF, 32'h5678, 1'b1}, 0, z},
			'{'{shth_pkg::REQ_LOOKUP, 64'hFFFFFFFFFFFFFFFF, 32'hFFFFFFFF, 32'h0, 1'b0}, 0, z},
			'{'{shth_pkg::REQ_LOOKUP, 64'hFFFFFFFFFFFFFFFF, 32'h0, 32'h0, 1'b0}, 0, z},
			'{'{shth_pkg::REQ_UPSERT, 64'h1, 32'h0, 32'h0, 1'b0}, 0, z},
			'{'{shth_pkg::REQ_LOOKUP, 64'h1, 32'h0, 32'h0, 1'b0}, 0, z},
			'{'{REQ_NOP, 64'hFFFFFFFFFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1}, 1,
				'{shth_pkg::ST_NOTFOUND, 1'b0, 32'd0, 1'b0, 11'd3}},
			'{'{shth_pkg::REQ_CLEAR, 64'h0, 32'h0, 32'h0, 1'b0}, 1,
				'{shth_pkg::ST_HIT, 1'b0, 32'd0, 1'b0, 11'd0}},
			'{'{shth_pkg::REQ_LOOKUP, 64'h0, 32'h0, 32'h0, 1'b0}, 1, z}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].ans);
		drain();

		// a single group fills up: full status and lookups over a full lap
		write_groups(3'd0);
		for (int i = 0; i < 10; i++) begin
			r = '{shth_pkg::REQ_UPSERT, {$urandom, $urandom}, $urandom, $urandom, 1'(i)};
			send_request(r, 0, z);
			r.op = shth_pkg::REQ_LOOKUP;
			send_request(r, 0, z);
		end
		drain();

		foreach (phase_cfg[p]) begin
			write_groups(phase_cfg[p]);
			for (int i = 0; i < 230; i++)
				send_request(random_request(phase_cfg[p] <= 3'd1), 0, z);
			drain();
		end

		if (pending_answers.size() != 0) begin
			$error("%0d responses never arrived", pending_answers.size());
			errors++;
		end
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
